// ===== sv/cidf_pkg.sv =====
// ----------------------------------------------------------------------------
// cidf_pkg
// Types and constants shared by the integer divide core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none
package cidf_pkg;

	localparam logic [1:0] MODE_DIVU_W = 2'd0;
	localparam logic [1:0] MODE_DIVS_W = 2'd1;
	localparam logic [1:0] MODE_DIVU_L = 2'd2;
	localparam logic [1:0] MODE_DIVS_L = 2'd3;

	localparam int FLAG_C = 0;
	localparam int FLAG_V = 1;
	localparam int FLAG_Z = 2;
	localparam int FLAG_N = 3;

	localparam int QBITS     = 32;
	localparam int BITS_STG  = 4;
	localparam int DIV_STG   = QBITS / BITS_STG;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] num;
		logic [31:0] ad;
		logic [31:0] rem;
		logic [31:0] lo;
		logic [3:0]  flags;
		logic        dz;
		logic        ovf;
		logic        nneg;
		logic        dneg;
	} div_stage_t;

endpackage
`default_nettype wire

// ===== sv/cpu_integer_divide_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// cpu_integer_divide_with_flags_core
// Pipelined word/long, signed/unsigned divide with N Z V C condition flags.
// ----------------------------------------------------------------------------
// channel | dir | fields (low bit first)
// s_axis  | in  | tuser: mode[1:0]; tdata: dividend[63:0] divisor[95:64] flags_in[99:96]
// m_axis  | out | tuser: div_by_zero; tdata: result[63:0] flags_out[67:64]
//
// One beat per cycle unless the output stalls. Stages: operand prep, eight stages of four
// restoring quotient steps each, then sign fix, flags and output register.
// The whole pipe advances when the output register is empty or taken.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_integer_divide_with_flags_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // dividend, divisor, flags_in, pad
	input  wire logic [1:0]   s_axis_tuser,  // mode
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,  // result, flags_out, pad
	output logic              m_axis_tuser   // div_by_zero
);

	localparam int NST = cidf_pkg::DIV_STG;
	localparam int BPS = cidf_pkg::BITS_STG;

	logic en;
	logic v_s [0:NST];
	cidf_pkg::div_stage_t div_s [0:NST];
	logic m_valid_q;
	logic [63:0] res_q;
	logic [3:0] flg_q;
	logic dz_q;

	assign en = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// prep
	logic [1:0]  in_mode;
	logic [63:0] in_num, in_nsx, in_an;
	logic [31:0] in_den, in_ad;
	logic        in_word, in_sgn, in_nneg, in_dneg;
	cidf_pkg::div_stage_t prep;

	always_comb begin
		in_mode = s_axis_tuser;
		in_word = !in_mode[1];
		in_sgn  = in_mode[0];
		in_den  = s_axis_tdata[95:64];
		in_num  = in_word ? {32'd0, s_axis_tdata[31:0]} : s_axis_tdata[63:0];
		in_nneg = in_sgn && (in_word ? in_num[31] : in_num[63]);
		in_dneg = in_sgn && in_den[31];
		in_nsx  = (in_word && in_nneg) ? {32'hffffffff, in_num[31:0]} : in_num;
		in_an   = in_nneg ? (~in_nsx + 64'd1) : in_nsx;
		in_ad   = in_dneg ? (~in_den + 32'd1) : in_den;
		prep.mode  = in_mode;
		prep.num   = in_num;
		prep.ad    = in_ad;
		prep.rem   = in_an[63:32];
		prep.lo    = in_an[31:0];
		prep.flags = s_axis_tdata[99:96];
		prep.dz    = (in_den == 32'd0);
		prep.ovf   = (in_an[63:32] >= in_ad);
		prep.nneg  = in_nneg;
		prep.dneg  = in_dneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= prep;
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_div
		cidf_pkg::div_stage_t nxt;
		always_comb begin
			logic [32:0] t;
			nxt = div_s[g];
			for (int k = 0; k < BPS; k++) begin
				t = {nxt.rem, nxt.lo[31]};
				if (t >= {1'b0, nxt.ad}) begin
					t = t - {1'b0, nxt.ad};
					nxt.lo = {nxt.lo[30:0], 1'b1};
				end else begin
					nxt.lo = {nxt.lo[30:0], 1'b0};
				end
				nxt.rem = t[31:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g+1] <= nxt;
			end
		end
	end

	// finish
	cidf_pkg::div_stage_t fs;
	logic        f_word, f_sgn, f_qneg, f_ovf;
	logic [31:0] f_q, f_r;
	logic [63:0] f_res;
	logic [3:0]  f_flg;

	always_comb begin
		fs     = div_s[NST];
		f_word = !fs.mode[1];
		f_sgn  = fs.mode[0];
		f_qneg = f_sgn && (fs.nneg != fs.dneg) && (fs.lo != 32'd0);
		f_ovf  = fs.ovf;
		if (f_sgn) begin
			if (f_word) begin
				f_ovf = f_ovf || (f_qneg ? (fs.lo > 32'h8000) : (fs.lo > 32'h7fff));
			end else begin
				f_ovf = f_ovf || (f_qneg ? (fs.lo > 32'h80000000) : (fs.lo > 32'h7fffffff));
			end
		end else if (f_word) begin
			f_ovf = f_ovf || (fs.lo > 32'hffff);
		end
		f_q = f_qneg ? (~fs.lo + 32'd1) : fs.lo;
		f_r = (f_sgn && fs.nneg && fs.rem != 32'd0) ? (~fs.rem + 32'd1) : fs.rem;
		f_flg = 4'd0;
		if (fs.dz) begin
			f_res = fs.num;
			f_flg = fs.flags;
		end else if (f_ovf) begin
			f_res = fs.num;
			f_flg = fs.flags;
			f_flg[cidf_pkg::FLAG_V] = 1'b1;
			f_flg[cidf_pkg::FLAG_C] = 1'b0;
		end else if (f_word) begin
			f_res = {32'd0, f_r[15:0], f_q[15:0]};
			if (f_q[15:0] == 16'd0) begin
				f_flg[cidf_pkg::FLAG_Z] = 1'b1;
			end else begin
				f_flg[cidf_pkg::FLAG_N] = f_q[15];
			end
		end else begin
			f_res = {f_r, f_q};
			if (f_q == 32'd0) begin
				f_flg[cidf_pkg::FLAG_Z] = 1'b1;
			end else begin
				f_flg[cidf_pkg::FLAG_N] = f_q[31];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= v_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= f_res;
			flg_q <= f_flg;
			dz_q  <= fs.dz;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, flg_q, res_q};
	assign m_axis_tuser  = dz_q;

endmodule
`default_nettype wire

// ===== sv/cpu_integer_divide_with_flags_core_chk.sv =====
// ----------------------------------------------------------------------------
// cpu_integer_divide_with_flags_core_chk
// Port-level checks for the divide core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_integer_divide_with_flags_core_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [103:0] s_axis_tdata,
	input wire logic [1:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [71:0]  m_axis_tdata,
	input wire logic         m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	a_carry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[64 + cidf_pkg::FLAG_C])
		else $error("C set after a divide");

	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && !m_axis_tdata[64 + cidf_pkg::FLAG_V]
		|-> !(m_axis_tdata[64 + cidf_pkg::FLAG_N] && m_axis_tdata[64 + cidf_pkg::FLAG_Z]))
		else $error("N and Z both set on a normal quotient");

endmodule

bind cpu_integer_divide_with_flags_core cpu_integer_divide_with_flags_core_chk u_chk (.*);
`default_nettype wire

// ===== sim/cidf_checker.sv =====
// ----------------------------------------------------------------------------
// cidf_checker
// Watches both stream channels of the divide core, predicts each result from
// the accepted operand beat and compares it field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module cidf_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,
	input  wire logic [1:0]   s_axis_tuser,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [71:0]  m_axis_tdata,
	input  wire logic         m_axis_tuser,
	output int                fail_count,
	output int                pending,
	output int                n_results
);

	typedef struct packed {
		logic [63:0] result;
		logic [3:0]  flags;
		logic        dz;
	} div_out_t;

	div_out_t expected_q[$];

	function automatic logic [63:0] negate(input logic [63:0] v, input logic neg);
		return neg ? (~v + 64'd1) : v;
	endfunction

	function automatic div_out_t divide_with_flags(input logic [1:0] mode,
		input logic [63:0] dividend, input logic [31:0] divisor, input logic [3:0] fin);
		div_out_t    o;
		logic        word, sgn, nneg, dneg, qneg, ovf;
		logic [63:0] num, dw, an, ad, q, r;
		word = (mode == cidf_pkg::MODE_DIVU_W) || (mode == cidf_pkg::MODE_DIVS_W);
		sgn  = (mode == cidf_pkg::MODE_DIVS_W) || (mode == cidf_pkg::MODE_DIVS_L);
		num  = word ? {32'd0, dividend[31:0]} : dividend;
		nneg = 1'b0;
		dneg = 1'b0;
		o.dz = 1'b0;
		if (divisor == 32'd0) begin
			o.result = num;
			o.flags  = fin;
			o.dz     = 1'b1;
			return o;
		end
		if (sgn) begin
			if (word) begin
				nneg = num[31];
				if (nneg) num[63:32] = 32'hffff_ffff;
			end else
				nneg = num[63];
			dneg = divisor[31];
			dw = {{32{divisor[31]}}, divisor};
			an = negate(num, nneg);
			ad = negate(dw, dneg);
			q = an / ad;
			r = an % ad;
			qneg = (nneg != dneg) && (q != 0);
			if (word) ovf = qneg ? (q > 64'h8000) : (q > 64'h7fff);
			else      ovf = qneg ? (q > 64'h8000_0000) : (q > 64'h7fff_ffff);
			q = negate(q, qneg);
			r = negate(r, nneg && (r != 0));
		end else begin
			q = num / {32'd0, divisor};
			r = num % {32'd0, divisor};
			ovf = word ? (q > 64'hffff) : (q > 64'hffff_ffff);
		end
		o.flags = 4'd0;
		if (ovf) begin
			if (word) begin
				o.flags[cidf_pkg::FLAG_Z] = fin[cidf_pkg::FLAG_Z];
				o.flags[cidf_pkg::FLAG_N] = fin[cidf_pkg::FLAG_N];
			end else begin
				o.flags = fin;
				o.flags[cidf_pkg::FLAG_C] = 1'b0;
			end
			o.flags[cidf_pkg::FLAG_V] = 1'b1;
			o.result = word ? {32'd0, num[31:0]} : num;
		end else if (word) begin
			if (q[15:0] == 16'd0) o.flags[cidf_pkg::FLAG_Z] = 1'b1;
			else if (q[15])       o.flags[cidf_pkg::FLAG_N] = 1'b1;
			o.result = {32'd0, r[15:0], q[15:0]};
		end else begin
			if (q[31:0] == 32'd0) o.flags[cidf_pkg::FLAG_Z] = 1'b1;
			else if (q[31])       o.flags[cidf_pkg::FLAG_N] = 1'b1;
			o.result = {r[31:0], q[31:0]};
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		div_out_t e;
		if (!arst_n) begin
			fail_count <= 0;
			n_results  <= 0;
			pending    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(divide_with_flags(s_axis_tuser, s_axis_tdata[63:0],
					s_axis_tdata[95:64], s_axis_tdata[99:96]));
			if (m_axis_tvalid && m_axis_tready) begin
				n_results <= n_results + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected beat result=%h flags=%h dz=%b", $time,
						m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (m_axis_tdata[63:0] !== e.result || m_axis_tdata[67:64] !== e.flags
						|| m_axis_tuser !== e.dz) begin
						$display("%0t: mismatch exp result=%h flags=%h dz=%b got %h %h %b",
							$time, e.result, e.flags, e.dz, m_axis_tdata[63:0],
							m_axis_tdata[67:64], m_axis_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== sim/tb_cpu_integer_divide_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// tb_cpu_integer_divide_with_flags_core
// Drives directed and random divide operands in all four modes under varying
// source gaps and sink stalls, including a long sink hold-off; a checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_cpu_integer_divide_with_flags_core;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;
	logic         m_axis_tuser;
	int           fail_count, pending, n_results;
	int           gap_pct = 0, stall_pct = 0, hold_cycles = 0;
	int           n_dz = 0;

	always #5 clk = ~clk;

	cpu_integer_divide_with_flags_core u_dut (.*);

	cidf_checker u_chk (.*);

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles   <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= arst_n && ($urandom_range(99, 0) >= stall_pct);
	end

	task automatic send_div(input logic [1:0] mode, input logic [63:0] dividend,
		input logic [31:0] divisor, input logic [3:0] fin);
		while ($urandom_range(99, 0) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {4'd0, fin, divisor, dividend};
		if (divisor == 0) n_dz++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_random();
		logic [1:0]  mode;
		logic [63:0] num;
		logic [31:0] den;
		int          k;
		mode = 2'($urandom_range(3, 0));
		num  = rnd64();
		den  = $urandom();
		k = $urandom_range(9, 0);
		case (k)
			0: den = '0;
			1: den = $urandom_range(255, 1);
			2: den = -$urandom_range(255, 1);
			3: num = num >> $urandom_range(63, 0);
			4: num = {{32{num[63]}}, num[31:0]};
			5: den = den >> $urandom_range(31, 0);
			6: num = {32'd0, $urandom() >> $urandom_range(31, 0)};
			default: ;
		endcase
		if (mode[1] && k inside {3, 4, 6, 7}) begin
			// keep long quotients in range most of the time
			num[63:32] = (den == 0) ? num[63:32] : (num[63:32] % (den | 1));
			if (mode == cidf_pkg::MODE_DIVS_L && num[63]) num[63:32] = ~num[63:32];
		end
		send_div(mode, num, den, 4'($urandom_range(15, 0)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_div(cidf_pkg::MODE_DIVU_W, 64'd100, 32'd7, 4'hf);
		send_div(cidf_pkg::MODE_DIVU_W, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 4'h0);
		send_div(cidf_pkg::MODE_DIVU_W, 64'h0001_0000, 32'd1, 4'hf);
		send_div(cidf_pkg::MODE_DIVU_W, 64'd5, 32'd0, 4'ha);
		send_div(cidf_pkg::MODE_DIVU_W, 64'd0, 32'd3, 4'h5);
		send_div(cidf_pkg::MODE_DIVU_W, 64'h0001_0000, 32'h1_0001, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_W, 64'hffff_ff9c, 32'd7, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_W, 64'h8000_0000, 32'hffff_ffff, 4'hf);
		send_div(cidf_pkg::MODE_DIVS_W, 64'hffff_8000, 32'd1, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_W, 64'h0000_8000, 32'hffff_ffff, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_W, 64'h0000_8000, 32'd1, 4'hf);
		send_div(cidf_pkg::MODE_DIVS_W, 64'd7, 32'd0, 4'h3);
		send_div(cidf_pkg::MODE_DIVU_L, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 4'hf);
		send_div(cidf_pkg::MODE_DIVU_L, 64'hffff_fffe_ffff_ffff, 32'hffff_ffff, 4'h0);
		send_div(cidf_pkg::MODE_DIVU_L, 64'h1_0000_0000, 32'd1, 4'hf);
		send_div(cidf_pkg::MODE_DIVU_L, 64'hdead_beef_0000_0001, 32'd0, 4'hc);
		send_div(cidf_pkg::MODE_DIVS_L, 64'h8000_0000_0000_0000, 32'hffff_ffff, 4'hf);
		send_div(cidf_pkg::MODE_DIVS_L, -64'd100, 32'd7, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_L, 64'd100, -32'd7, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_L, -64'h8000_0000, 32'd1, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_L, 64'h8000_0000, 32'hffff_ffff, 4'h0);
		send_div(cidf_pkg::MODE_DIVS_L, 64'h7fff_ffff_ffff_ffff, 32'h8000_0000, 4'h6);
		send_div(cidf_pkg::MODE_DIVS_L, 64'd0, 32'h8000_0000, 4'h9);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 59; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 59; end
				3: begin gap_pct = 35; stall_pct = 35; end
				default: begin gap_pct = 0; stall_pct = 0; hold_cycles = 200; end
			endcase
			for (int i = 0; i < 305; i++) send_random();
		end
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d results over all four divide modes, %0d with zero divisor,",
			n_results, n_dz);
		$display("with source gaps, sink stalls and a long sink hold-off.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/cidf_pkg.sv
sv/cpu_integer_divide_with_flags_core.sv
sv/cpu_integer_divide_with_flags_core_chk.sv
sim/cidf_checker.sv
sim/tb_cpu_integer_divide_with_flags_core.sv
